/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* rtl/vjpc_pkg.sv */
// ----------------------------------------------------------------------------
// vjpc_pkg
// Sizes shared by the variable jump path counter.
// ----------------------------------------------------------------------------
`default_nettype none

package vjpc_pkg;
    localparam int MAX_STAIRS = 32;
    localparam int JUMP_W     = 6;
    localparam int PATH_W     = 32;
    localparam int COUNT_W    = $clog2(MAX_STAIRS + 1);
    localparam int JADDR_W    = (MAX_STAIRS > 1) ? $clog2(MAX_STAIRS) : 1;
    localparam int WAYS_DEPTH = MAX_STAIRS + 1;
    localparam int CMP_W      = (JUMP_W > COUNT_W) ? JUMP_W : COUNT_W;
endpackage

`default_nettype wire

/* rtl/variable_jump_path_counter.sv */
// ----------------------------------------------------------------------------
// variable_jump_path_counter
// Loads one jump limit per stair, then counts paths from stair 0 to the top
// with a backward pass over a path-count RAM using one shared adder.
//
// Channel  Dir  Handshake           Content
// s_       in   s_tvalid/s_tready   tdata[5:0] jump_length, tlast is_last
// m_       out  m_tvalid/m_tready   tdata[31:0] path_count
//
// Loading accepts one request per cycle while idle. After the last request the
// pass walks the stairs from the top down, adding each reachable path count in
// turn on the single adder and RAM read port, then hands the result over; the
// hand-over waits while an earlier result is still held.
// s_tready is low during the pass; loading resumes while a result waits.
// Reset (aresetn low, synchronous) empties the staircase and the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module variable_jump_path_counter import vjpc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [5:0] jump_length, [7:6] zero
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] path_count
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_JREQ = 3'd2;
    localparam logic [2:0] ST_JGET = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_WR   = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [COUNT_W-1:0] s_reg, s_next;
    logic [COUNT_W-1:0] k_reg, k_next;
    logic [COUNT_W-1:0] reach_reg, reach_next;
    logic [PATH_W-1:0]  total_reg, total_next;
    logic               mvalid_reg, mvalid_next;
    logic [PATH_W-1:0]  mdata_reg, mdata_next;

    logic               accept;
    logic               has_room;
    logic [COUNT_W-1:0] s_dec;
    logic [COUNT_W-1:0] span;
    logic [CMP_W-1:0]   jump_ext;
    logic [CMP_W-1:0]   span_ext;

    logic               j_we;
    logic [JADDR_W-1:0] j_waddr;
    logic [JADDR_W-1:0] j_raddr;
    logic [JUMP_W-1:0]  j_rdata;

    logic               w_we;
    logic [COUNT_W-1:0] w_waddr;
    logic [PATH_W-1:0]  w_wdata;
    logic [COUNT_W-1:0] w_raddr;
    logic [PATH_W-1:0]  w_rdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign has_room = (count_reg < COUNT_W'(MAX_STAIRS));
    assign s_dec    = s_reg - COUNT_W'(1);
    assign span     = n_reg - s_reg;
    assign jump_ext = CMP_W'(j_rdata);
    assign span_ext = CMP_W'(span);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    assign j_we    = accept && has_room;
    assign j_waddr = count_reg[JADDR_W-1:0];
    assign j_raddr = s_dec[JADDR_W-1:0];

    assign w_we    = (state_reg == ST_INIT) || (state_reg == ST_WR);
    assign w_waddr = (state_reg == ST_INIT) ? n_reg : s_reg;
    assign w_wdata = (state_reg == ST_INIT) ? PATH_W'(1) : total_reg;
    assign w_raddr = s_reg + k_reg;

    vjpc_ram #(.WIDTH(JUMP_W), .DEPTH(MAX_STAIRS)) u_jump_ram (
        .clk   (aclk),
        .we    (j_we),
        .waddr (j_waddr),
        .wdata (s_tdata[JUMP_W-1:0]),
        .raddr (j_raddr),
        .rdata (j_rdata)
    );

    vjpc_ram #(.WIDTH(PATH_W), .DEPTH(WAYS_DEPTH)) u_ways_ram (
        .clk   (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        s_next      = s_reg;
        k_next      = k_reg;
        reach_next  = reach_reg;
        total_next  = total_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tlast) begin
                        n_next     = has_room ? count_reg + COUNT_W'(1) : count_reg;
                        count_next = '0;
                        state_next = ST_INIT;
                    end else if (has_room) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end
            ST_INIT: begin
                s_next     = n_reg;
                state_next = ST_JREQ;
            end
            ST_JREQ: begin
                s_next     = s_dec;
                state_next = ST_JGET;
            end
            ST_JGET: begin
                reach_next = (jump_ext > span_ext) ? span : COUNT_W'(j_rdata);
                k_next     = COUNT_W'(1);
                total_next = '0;
                if ((jump_ext == '0) || (span == '0)) begin
                    state_next = ST_WR;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                total_next = total_reg + w_rdata;
                if (k_reg == reach_reg) begin
                    state_next = ST_WR;
                end else begin
                    k_next     = k_reg + COUNT_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_WR: begin
                if (s_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_JREQ;
                end
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = total_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
        end
        n_reg     <= n_next;
        s_reg     <= s_next;
        k_reg     <= k_next;
        reach_reg <= reach_next;
        total_reg <= total_next;
        mdata_reg <= mdata_next;
    end

    `ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > COUNT_W'(MAX_STAIRS))
    `ASSERT_PROP(a_k_in_range, aclk, aresetn,
        (state_reg == ST_ACC) |-> ((k_reg != '0) && (k_reg <= reach_reg)))
    `ASSERT_PROP(a_read_below_top, aclk, aresetn,
        (state_reg == ST_RD) |-> ((s_reg + k_reg) <= n_reg))
    `ASSERT_PROP(a_out_at_bottom, aclk, aresetn,
        (state_reg == ST_OUT) |-> (s_reg == '0))
    `ASSERT_PROP(a_result_follows_out, aclk, aresetn,
        ((state_reg == ST_OUT) && (!mvalid_reg || m_tready)) |=> mvalid_reg)
endmodule

`default_nettype wire

/* rtl/vjpc_ram.sv */
// ----------------------------------------------------------------------------
// vjpc_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vjpc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire
